// ===== rtl/ced_pkg.sv =====
// Shared word and queue entry types for the C escape sequence decoder.
package ced_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_final;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        end_of_string;
    logic [11:0] decoded_count;
  } out_word_t;

  // One decoded item: one or two result words.
  typedef struct packed {
    logic      two;
    out_word_t w0;
    out_word_t w1;
  } ced_entry_t;

endpackage

// ===== rtl/ced_front.sv =====
// Front end: accepts source bytes, runs the escape state machine, builds result entries.
module ced_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  ced_pkg::in_word_t     in_word_i,
  input  logic                  cfg_we_i,
  input  logic [11:0]           cfg_data_i,
  output logic                  entry_valid_o,
  output ced_pkg::ced_entry_t   entry_o
);

  typedef enum logic [1:0] {
    MODE_TEXT,
    MODE_ESC,
    MODE_HEX,
    MODE_OCT
  } mode_e;

  localparam logic [15:0] LimitMax     = 16'd4095;
  localparam logic [11:0] LimitReset   = 12'd256;
  localparam logic [7:0]  CharBackslash = 8'h5C;
  localparam logic [7:0]  CharX         = 8'h78;
  localparam logic [7:0]  CharNul       = 8'h00;

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39)      r = {1'b1, 4'(b - 8'h30)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
    return r;
  endfunction

  // {valid, character}
  function automatic logic [8:0] simple_escape(input logic [7:0] b);
    logic [8:0] r;
    r = '0;
    unique case (b)
      8'h61:   r = {1'b1, 8'd7};
      8'h62:   r = {1'b1, 8'd8};
      8'h66:   r = {1'b1, 8'd12};
      8'h6E:   r = {1'b1, 8'd10};
      8'h72:   r = {1'b1, 8'd13};
      8'h74:   r = {1'b1, 8'd9};
      8'h76:   r = {1'b1, 8'd11};
      8'h5C:   r = {1'b1, 8'd92};
      8'h27:   r = {1'b1, 8'd39};
      8'h22:   r = {1'b1, 8'd34};
      8'h3F:   r = {1'b1, 8'd63};
      default: r = '0;
    endcase
    return r;
  endfunction

  mode_e       mode_q, mode_d;
  logic [8:0]  dv_q, dv_d;
  logic [1:0]  dc_q, dc_d;
  logic [11:0] cnt_q, cnt_d;
  logic        stop_q, stop_d;
  logic [11:0] limit_q;

  logic [11:0]        limit;
  logic [1:0]         n;
  ced_pkg::out_word_t w0, w1;
  logic [7:0]         b;
  logic               fin;
  logic [4:0]         hx;
  logic [8:0]         se;
  logic               oct;
  logic               room2;

  always_comb begin
    b      = in_word_i.in_byte;
    fin    = in_word_i.is_final;
    hx     = hex_digit(b);
    se     = simple_escape(b);
    oct    = (b >= 8'h30) && (b <= 8'h37);
    limit  = ({4'b0, limit_q} < LimitMax) ? limit_q : LimitMax[11:0];
    mode_d = mode_q;
    dv_d   = dv_q;
    dc_d   = dc_q;
    cnt_d  = cnt_q;
    stop_d = stop_q;
    n      = 2'd0;
    w0     = '0;
    w1     = '0;

    // Limit at or below the count: stop and drop any partial escape.
    if (!stop_d && cnt_d >= limit) begin
      stop_d = 1'b1;
      mode_d = MODE_TEXT;
    end
    room2 = ({1'b0, cnt_d} + 13'd1) < {1'b0, limit};

    if (!stop_d) begin
      unique case (mode_d) inside
        MODE_ESC: begin
          mode_d = MODE_TEXT;
          if (se[8]) begin
            cnt_d = cnt_d + 12'd1;
            w0 = '{out_byte: se[7:0], has_byte: 1'b1, end_of_string: 1'b0,
                   decoded_count: cnt_d};
            n = 2'd1;
          end else if (b == CharX) begin
            if (fin) begin
              if (room2) begin
                w0 = '{out_byte: CharBackslash, has_byte: 1'b1, end_of_string: 1'b0,
                       decoded_count: cnt_d + 12'd1};
                w1 = '{out_byte: CharX, has_byte: 1'b1, end_of_string: 1'b0,
                       decoded_count: cnt_d + 12'd2};
                cnt_d = cnt_d + 12'd2;
                n = 2'd2;
              end
            end else begin
              mode_d = MODE_HEX;
              dc_d   = 2'd0;
              dv_d   = '0;
            end
          end else if (oct) begin
            dv_d = {6'b0, b[2:0]};
            dc_d = 2'd1;
            if (fin) begin
              cnt_d = cnt_d + 12'd1;
              w0 = '{out_byte: dv_d[7:0], has_byte: 1'b1, end_of_string: 1'b0,
                     decoded_count: cnt_d};
              n = 2'd1;
            end else begin
              mode_d = MODE_OCT;
            end
          end else if (room2) begin
            w0 = '{out_byte: CharBackslash, has_byte: 1'b1, end_of_string: 1'b0,
                   decoded_count: cnt_d + 12'd1};
            w1 = '{out_byte: b, has_byte: 1'b1, end_of_string: 1'b0,
                   decoded_count: cnt_d + 12'd2};
            cnt_d = cnt_d + 12'd2;
            n = 2'd2;
          end
        end
        MODE_HEX, MODE_OCT: begin
          logic pending;
          pending = 1'b0;
          if (mode_d == MODE_HEX && dc_d == 2'd0) begin
            if (hx[4]) begin
              dv_d = {5'b0, hx[3:0]};
              if (fin) begin
                cnt_d = cnt_d + 12'd1;
                w0 = '{out_byte: dv_d[7:0], has_byte: 1'b1, end_of_string: 1'b0,
                       decoded_count: cnt_d};
                n = 2'd1;
                mode_d = MODE_TEXT;
              end else begin
                dc_d = 2'd1;
              end
            end else begin
              // Bad \x: emit backslash and x if both fit under the limit; drop this byte.
              mode_d = MODE_TEXT;
              if (room2) begin
                w0 = '{out_byte: CharBackslash, has_byte: 1'b1, end_of_string: 1'b0,
                       decoded_count: cnt_d + 12'd1};
                w1 = '{out_byte: CharX, has_byte: 1'b1, end_of_string: 1'b0,
                       decoded_count: cnt_d + 12'd2};
                cnt_d = cnt_d + 12'd2;
                n = 2'd2;
              end
            end
          end else if (mode_d == MODE_HEX) begin
            mode_d = MODE_TEXT;
            cnt_d = cnt_d + 12'd1;
            w0 = '{out_byte: hx[4] ? {dv_d[3:0], hx[3:0]} : dv_d[7:0], has_byte: 1'b1,
                   end_of_string: 1'b0, decoded_count: cnt_d};
            n = 2'd1;
            pending = !hx[4];
          end else if (oct) begin
            dv_d = {dv_d[5:0], b[2:0]};
            dc_d = dc_d + 2'd1;
            if (dc_d == 2'd3 || fin) begin
              cnt_d = cnt_d + 12'd1;
              w0 = '{out_byte: dv_d[7:0], has_byte: 1'b1, end_of_string: 1'b0,
                     decoded_count: cnt_d};
              n = 2'd1;
              mode_d = MODE_TEXT;
            end
          end else begin
            mode_d = MODE_TEXT;
            cnt_d = cnt_d + 12'd1;
            w0 = '{out_byte: dv_d[7:0], has_byte: 1'b1, end_of_string: 1'b0,
                   decoded_count: cnt_d};
            n = 2'd1;
            pending = 1'b1;
          end
          // Terminating byte of a short escape is handled as text.
          if (pending) begin
            if (cnt_d >= limit) begin
              stop_d = 1'b1;
            end else if (b == CharNul) begin
              stop_d = 1'b1;
            end else if (b == CharBackslash && !fin) begin
              mode_d = MODE_ESC;
            end else begin
              cnt_d = cnt_d + 12'd1;
              w1 = '{out_byte: b, has_byte: 1'b1, end_of_string: 1'b0,
                     decoded_count: cnt_d};
              n = 2'd2;
            end
          end
        end
        default: begin
          if (b == CharNul) begin
            stop_d = 1'b1;
          end else if (b == CharBackslash && !fin) begin
            mode_d = MODE_ESC;
          end else begin
            cnt_d = cnt_d + 12'd1;
            w0 = '{out_byte: b, has_byte: 1'b1, end_of_string: 1'b0,
                   decoded_count: cnt_d};
            n = 2'd1;
          end
        end
      endcase
    end

    // Close the string: mark the last word, or add a bare end marker.
    if (fin) begin
      if (n == 2'd0) begin
        w0.end_of_string = 1'b1;
        w0.decoded_count = cnt_d;
        n = 2'd1;
      end else if (n == 2'd1) begin
        w0.end_of_string = 1'b1;
      end else begin
        w1.end_of_string = 1'b1;
      end
      mode_d = MODE_TEXT;
      dv_d   = '0;
      dc_d   = 2'd0;
      cnt_d  = '0;
      stop_d = 1'b0;
    end
  end

  assign entry_valid_o = accept_i && (n != 2'd0);
  assign entry_o       = '{two: (n == 2'd2), w0: w0, w1: w1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_TEXT;
      dv_q    <= '0;
      dc_q    <= 2'd0;
      cnt_q   <= '0;
      stop_q  <= 1'b0;
      limit_q <= LimitReset;
    end else begin
      if (accept_i) begin
        mode_q <= mode_d;
        dv_q   <= dv_d;
        dc_q   <= dc_d;
        cnt_q  <= cnt_d;
        stop_q <= stop_d;
      end
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

endmodule

// ===== rtl/ced_fifo.sv =====
// Entry queue between the decode front end and the output back end.
module ced_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ced_pkg::ced_entry_t wr_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output ced_pkg::ced_entry_t rd_data_o,
  output logic                empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

  ced_pkg::ced_entry_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] count_q;

  assign full_o    = (count_q == CntW'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== rtl/ced_back.sv =====
// Back end: takes queued entries and hands out their result words one at a time.
module ced_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  ced_pkg::ced_entry_t q_data_i,
  output logic                q_pop_o,
  output ced_pkg::out_word_t  out_word_o,
  output logic                empty_o,
  input  logic                pop_i
);

  ced_pkg::ced_entry_t cur_q;
  logic                valid_q;
  logic                sel_q;
  logic                last;
  logic                take;

  assign last       = !cur_q.two || sel_q;
  assign take       = !valid_q || (pop_i && last);
  assign q_pop_o    = take && !q_empty_i;
  assign empty_o    = !valid_q;
  assign out_word_o = sel_q ? cur_q.w1 : cur_q.w0;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else if (take) begin
      valid_q <= !q_empty_i;
      sel_q   <= 1'b0;
    end else if (pop_i) begin
      // advance to the second word of a two-word entry
      sel_q <= 1'b1;
    end
  end

endmodule

// ===== rtl/c_escape_sequence_decoder.sv =====
// Top level of the streaming C escape sequence decoder.
// Input: one source byte per word with a final-byte flag, taken when push is
//   high and full is low. Output: decoded words, the oldest shown while empty
//   is low, taken when pop is high. Each word carries the byte, a has-byte
//   flag, an end-of-string flag and the running decoded count.
// Config: cfg_data_i is the output limit, written when cfg_valid_i is high;
//   cfg_ready_o is always high. Write it only while the block is idle.
// Throughput: one source byte per cycle while full is low, decoded
//   combinationally by the front end; the back end delivers one result word
//   per cycle while pop is high. A byte may yield two words (invalid escapes,
//   or short ones ended by text). Words go through the queue, then the back end.
// FIFO_DEPTH entries of up to two words sit between the front and back ends;
//   full rises when they are all taken, so a stalled receiver backs up the
//   input only after the queue fills. No word is lost or repeated.
// Reset: all queues empty, decoder in text mode, count zero, limit 256.
module c_escape_sequence_decoder #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  ced_pkg::in_word_t  in_word_i,
  output logic               full,
  output ced_pkg::out_word_t out_word_o,
  output logic               empty,
  input  logic               pop,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [11:0]        cfg_data_i
);

  logic                entry_valid;
  ced_pkg::ced_entry_t entry;
  ced_pkg::ced_entry_t q_data;
  logic                q_empty;
  logic                q_pop;
  logic                accept;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  ced_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_word_i     (in_word_i),
    .cfg_we_i      (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .entry_valid_o (entry_valid),
    .entry_o       (entry)
  );

  ced_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (entry_valid),
    .wr_data_i (entry),
    .full_o    (full),
    .pop_i     (q_pop),
    .rd_data_o (q_data),
    .empty_o   (q_empty)
  );

  ced_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_data_i   (q_data),
    .q_pop_o    (q_pop),
    .out_word_o (out_word_o),
    .empty_o    (empty),
    .pop_i      (pop)
  );

endmodule

// ===== test/tb_c_escape_sequence_decoder.sv =====
// Self-checking testbench for the streaming C escape sequence decoder.
`timescale 1ns / 1ps

module tb_c_escape_sequence_decoder;

  localparam int unsigned LIMIT_MAX = 4095;
  localparam int unsigned RANDOM_ITEMS = 350;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_X = "x";
  localparam logic [7:0] CH_ZERO = "0";
  localparam logic [7:0] CH_SEVEN = "7";

  typedef enum logic [1:0] {DEC_TEXT, DEC_ESC, DEC_HEX, DEC_OCT} dec_mode_e;

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  ced_pkg::in_word_t  in_word_i;
  logic               full;
  ced_pkg::out_word_t out_word_o;
  logic               empty;
  logic               pop;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [11:0]        cfg_data_i;

  c_escape_sequence_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_word_i  (in_word_i),
    .full       (full),
    .out_word_o (out_word_o),
    .empty      (empty),
    .pop        (pop),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // Decoder state as the testbench sees it
  dec_mode_e   mode_q;
  logic [8:0]  digits_q;
  logic [1:0]  ndigits_q;
  int unsigned run_count;
  bit          halted_q;
  logic [11:0] limit_q;
  int unsigned limit_now;
  int unsigned sent_items;

  ced_pkg::out_word_t step_words[$];
  ced_pkg::out_word_t expected_words[$];
  ced_pkg::out_word_t exp_word;
  logic [7:0]  src_bytes[$];
  int          fail_count;
  bit          send_idle_on;
  bit          recv_idle_on;

  string esc_letters = "abfnrtv\\'\"?";
  string hex_chars = "0123456789abcdefABCDEF";

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("** c_escape_sequence_decoder: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void emit_byte(logic [7:0] b);
    ced_pkg::out_word_t w;
    if (step_words.size() < 2) begin
      run_count++;
      w.out_byte = b;
      w.has_byte = 1'b1;
      w.end_of_string = 1'b0;
      w.decoded_count = run_count[11:0];
      step_words.push_back(w);
    end
  endfunction

  function automatic void emit_pair(logic [7:0] a, logic [7:0] b);
    if (run_count + 1 < limit_now) begin
      emit_byte(a);
      emit_byte(b);
    end
  endfunction

  function automatic int hex_digit(logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  function automatic bit is_octal(logic [7:0] b);
    return b >= CH_ZERO && b <= CH_SEVEN;
  endfunction

  // Returns 256 when the byte is not one of the simple escapes.
  function automatic int escape_value(logic [7:0] b);
    unique case (b) inside
      "a": return 7;
      "b": return 8;
      "f": return 12;
      "n": return 10;
      "r": return 13;
      "t": return 9;
      "v": return 11;
      "\\", "'", "\"", "?": return int'(b);
      default: return 256;
    endcase
  endfunction

  function automatic void text_char(logic [7:0] b, bit fin);
    mode_q = DEC_TEXT;
    if (b == CH_NUL) begin
      halted_q = 1'b1;
    end else if (b == CH_BSLASH && !fin) begin
      mode_q = DEC_ESC;
    end else begin
      emit_byte(b);
    end
  endfunction

  function automatic void after_digits(logic [7:0] b, bit fin);
    mode_q = DEC_TEXT;
    if (run_count >= limit_now) halted_q = 1'b1;
    else text_char(b, fin);
  endfunction

  function automatic void decode_word(ced_pkg::in_word_t w);
    int h;
    int m;
    ced_pkg::out_word_t marker;
    step_words.delete();
    sent_items++;
    limit_now = (limit_q < LIMIT_MAX) ? limit_q : LIMIT_MAX;
    if (!halted_q && run_count >= limit_now) begin
      halted_q = 1'b1;
      mode_q = DEC_TEXT;
    end
    if (!halted_q) begin
      case (mode_q)
        DEC_ESC: begin
          mode_q = DEC_TEXT;
          m = escape_value(w.in_byte);
          if (m < 256) begin
            emit_byte(m[7:0]);
          end else if (w.in_byte == CH_X) begin
            if (w.is_final) begin
              emit_pair(CH_BSLASH, CH_X);
            end else begin
              mode_q = DEC_HEX;
              ndigits_q = 0;
              digits_q = 0;
            end
          end else if (is_octal(w.in_byte)) begin
            digits_q = 9'(w.in_byte - CH_ZERO);
            ndigits_q = 1;
            if (w.is_final) emit_byte(digits_q[7:0]);
            else mode_q = DEC_OCT;
          end else begin
            emit_pair(CH_BSLASH, w.in_byte);
          end
        end
        DEC_HEX: begin
          h = hex_digit(w.in_byte);
          if (ndigits_q == 0) begin
            if (h >= 0) begin
              digits_q = 9'(h);
              if (w.is_final) begin
                emit_byte(digits_q[7:0]);
                mode_q = DEC_TEXT;
              end else begin
                ndigits_q = 1;
              end
            end else begin
              mode_q = DEC_TEXT;
              emit_pair(CH_BSLASH, CH_X);
            end
          end else begin
            mode_q = DEC_TEXT;
            if (h >= 0) begin
              emit_byte({digits_q[3:0], 4'(h)});
            end else begin
              emit_byte(digits_q[7:0]);
              after_digits(w.in_byte, w.is_final);
            end
          end
        end
        DEC_OCT: begin
          if (is_octal(w.in_byte)) begin
            digits_q = {digits_q[5:0], 3'(w.in_byte - CH_ZERO)};
            ndigits_q++;
            if (ndigits_q == 3 || w.is_final) begin
              emit_byte(digits_q[7:0]);
              mode_q = DEC_TEXT;
            end
          end else begin
            mode_q = DEC_TEXT;
            emit_byte(digits_q[7:0]);
            after_digits(w.in_byte, w.is_final);
          end
        end
        default: text_char(w.in_byte, w.is_final);
      endcase
    end
    if (w.is_final) begin
      if (step_words.size() == 0) begin
        marker = '0;
        marker.end_of_string = 1'b1;
        marker.decoded_count = run_count[11:0];
        step_words.push_back(marker);
      end else begin
        step_words[step_words.size() - 1].end_of_string = 1'b1;
      end
      mode_q = DEC_TEXT;
      digits_q = 0;
      ndigits_q = 0;
      run_count = 0;
      halted_q = 1'b0;
    end
    foreach (step_words[i]) expected_words.push_back(step_words[i]);
  endfunction

  // ------------------------------------------------------------------ checker

  task automatic note_mismatch(string what, ced_pkg::out_word_t want,
                               ced_pkg::out_word_t got);
    if (fail_count < 10)
      $display("%0t: %s: exp %h/%b/%b/%0d got %h/%b/%b/%0d",
               $realtime, what, want.out_byte, want.has_byte, want.end_of_string,
               want.decoded_count, got.out_byte, got.has_byte, got.end_of_string,
               got.decoded_count);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_words.size() == 0) begin
        note_mismatch("unexpected word", '0, out_word_o);
      end else begin
        exp_word = expected_words.pop_front();
        if (out_word_o.out_byte !== exp_word.out_byte ||
            out_word_o.has_byte !== exp_word.has_byte ||
            out_word_o.end_of_string !== exp_word.end_of_string ||
            out_word_o.decoded_count !== exp_word.decoded_count)
          note_mismatch("word mismatch", exp_word, out_word_o);
      end
    end
  end

  // Receiver: when recv_idle_on is set, stall a random number of cycles before each word.
  initial begin : drain
    int gap;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = recv_idle_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  // ------------------------------------------------------------------ drivers

  task automatic send_word(logic [7:0] b, bit fin);
    int gap;
    ced_pkg::in_word_t w;
    gap = send_idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    w.in_byte = b;
    w.is_final = fin;
    push <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (full);
    decode_word(w);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], i == s.len() - 1);
  endtask

  // Drain all expected words, then give the pipeline time to settle.
  task automatic wait_idle();
    int spins;
    push <= 1'b0;
    spins = 0;
    while (expected_words.size() != 0 && spins < 2000) begin
      @(posedge clk_i);
      spins++;
    end
    if (expected_words.size() != 0) begin
      $display("%0t: %0d words never arrived", $realtime, expected_words.size());
      fail_count++;
      expected_words.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [11:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    limit_q = value;
  endtask

  // ------------------------------------------------------------ string maker

  task automatic add_piece();
    int kind;
    kind = $urandom_range(0, 9);
    case (kind) inside
      0, 1, 2: repeat ($urandom_range(1, 4))
        src_bytes.push_back(8'($urandom_range(32, 126)));
      3: begin
        src_bytes.push_back(CH_BSLASH);
        src_bytes.push_back(esc_letters[$urandom_range(0, esc_letters.len() - 1)]);
      end
      4: begin
        src_bytes.push_back(CH_BSLASH);
        src_bytes.push_back(CH_X);
        repeat ($urandom_range(1, 2))
          src_bytes.push_back(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
      end
      5: begin
        src_bytes.push_back(CH_BSLASH);
        repeat ($urandom_range(1, 3))
          src_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
      end
      6: begin
        src_bytes.push_back(CH_BSLASH);
        src_bytes.push_back(8'($urandom_range(0, 255)));
      end
      7: begin
        src_bytes.push_back(CH_BSLASH);
        src_bytes.push_back(CH_X);
        src_bytes.push_back(8'($urandom_range(0, 255)));
      end
      8: src_bytes.push_back(($urandom_range(0, 2) == 0) ? CH_NUL : 8'($urandom_range(0, 255)));
      default: src_bytes.push_back(CH_BSLASH);
    endcase
  endtask

  function automatic logic [11:0] pick_limit();
    case ($urandom_range(0, 9))
      0: return 12'd0;
      1: return 12'd4095;
      2: return 12'($urandom_range(1, 3));
      3: return 12'd256;
      default: return 12'($urandom_range(4, 48));
    endcase
  endfunction

  // -------------------------------------------------------------------- tests

  task automatic test_escapes();
    send_text("\\n");
    send_text("\\x4f");
    send_text("\\x7g");
    send_text("\\xzq");
    send_text("\\101");
    send_text("\\7");
    send_text("\\q");
    send_text("\\");
    send_word("a", 1'b0);
    send_word(CH_NUL, 1'b0);
    send_word("b", 1'b1);
    send_word(8'hff, 1'b1);
    wait_idle();
  endtask

  // Run one long string into the limit left by reset.
  task automatic test_reset_limit();
    repeat (299) send_word(8'($urandom_range(1, 255)), 1'b0);
    send_word(8'($urandom_range(1, 255)), 1'b1);
    wait_idle();
  endtask

  task automatic test_limit_edges();
    write_limit(12'd0);
    send_text("ab");
    wait_idle();
    write_limit(12'd3);
    send_text("ab\\qc");
    wait_idle();
    write_limit(12'd2);
    send_text("a\\7z");
    wait_idle();
    // lower the limit while an octal escape is half done
    write_limit(12'd8);
    send_word("a", 1'b0);
    send_word(CH_BSLASH, 1'b0);
    send_word("1", 1'b0);
    wait_idle();
    write_limit(12'd1);
    send_text("2c");
    wait_idle();
    write_limit(12'd4095);
    send_text("\\x41\\?");
    wait_idle();
  endtask

  task automatic test_random_strings();
    int unsigned sent_base;
    int split;
    sent_base = sent_items;
    while (sent_items < sent_base + RANDOM_ITEMS) begin
      wait_idle();
      write_limit(pick_limit());
      send_idle_on = ($urandom_range(0, 3) != 0);
      recv_idle_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 6)) begin
        src_bytes.delete();
        repeat ($urandom_range(1, 8)) add_piece();
        split = -1;
        if (src_bytes.size() > 1 && $urandom_range(0, 9) == 0)
          split = $urandom_range(1, src_bytes.size() - 1);
        foreach (src_bytes[i]) begin
          if (i == split) begin
            wait_idle();
            write_limit(pick_limit());
          end
          send_word(src_bytes[i], i == src_bytes.size() - 1);
        end
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    push <= 1'b0;
    in_word_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    mode_q = DEC_TEXT;
    digits_q = 0;
    ndigits_q = 0;
    run_count = 0;
    halted_q = 1'b0;
    limit_q = 12'd256;
    sent_items = 0;
    fail_count = 0;
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_escapes();
    test_reset_limit();
    test_limit_edges();
    test_random_strings();
    wait_idle();

    if (fail_count == 0) begin
      $display("** c_escape_sequence_decoder: PASSED **");
    end else begin
      $display("** c_escape_sequence_decoder: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ced_pkg.sv
rtl/ced_front.sv
rtl/ced_fifo.sv
rtl/ced_back.sv
rtl/c_escape_sequence_decoder.sv
test/tb_c_escape_sequence_decoder.sv
